// ===== sv/cmm_pkg.sv =====
// Shared constants and types for the colour mask morphology unit.
// No dependencies; every file but cmm_ram and cmm_checker imports this package.
`default_nettype none

package cmm_pkg;

  // Line memory geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // Register and field widths
  localparam int GAIN_W    = 8;
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  // Effective width and pending count must hold MAX_WIDTH + 1
  localparam int EFF_W = (WIDTH_W > COL_W + 1) ? WIDTH_W : COL_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  // Reset values of the registers
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 8'd2;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

  // Smallest frame extent
  localparam int MIN_EXTENT = 3;

  // Bit positions of the two line buffers in one memory word
  localparam int LINE_UPPER  = 0;
  localparam int LINE_MIDDLE = 1;
  localparam int LINE_W      = 2;

  // 3x3 window
  localparam int WIN_BITS  = 9;
  localparam int WIN_CNT_W = 4;
  localparam int CENTRE    = 4;
  localparam int MAJ_LIMIT = 4;

  // Request held between the memory read and the write-back
  typedef struct packed {
    logic              valid;
    logic              pixel;
    logic              emit;
    logic              border;
    logic              frame_end;
    logic              sel_upper;
    logic              fg;
    logic              fwd;
    logic [LINE_W-1:0] fwd_data;
    logic [COL_W-1:0]  addr;
  } cmm_stage_t;

  // Line memory write-back
  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  addr;
    logic [LINE_W-1:0] data;
  } cmm_wr_t;

endpackage

`default_nettype wire

// ===== sv/cmm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module cmm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cmm_front.sv =====
// Front end: configuration registers, thresholding, raster counters,
// line memory read request and forwarding check. Depends on cmm_pkg.
`default_nettype none

module cmm_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         pixel_valid,
  output logic                              pixel_stall,
  input  wire logic                         operation,
  input  wire logic [cmm_pkg::GAIN_W-1:0]   red,
  input  wire logic [cmm_pkg::GAIN_W-1:0]   green,
  input  wire logic                         cfg_write,
  input  wire logic [cmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cmm_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                         advance,
  input  wire cmm_pkg::cmm_wr_t             wr,
  output logic                              rd_en,
  output logic      [cmm_pkg::COL_W-1:0]    rd_addr,
  output cmm_pkg::cmm_stage_t               stage,
  output logic                              restart
);

  import cmm_pkg::*;

  logic [GAIN_W-1:0]   green_gain;
  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [COL_W-1:0]    in_column;
  logic [HEIGHT_W-1:0] in_row;
  logic [COL_W-1:0]    out_column;
  logic [HEIGHT_W-1:0] out_row;
  logic [EFF_W-1:0]    pending_count;

  logic [EFF_W-1:0]    eff_w;
  logic [COL_W-1:0]    w_m1;
  logic [HEIGHT_W-1:0] eff_h;
  logic [HEIGHT_W-1:0] h_m1;
  logic [2*GAIN_W-1:0] product;
  logic                fg;
  logic                accept;
  logic                emit;
  logic                sel_upper;
  logic                border;
  logic                last_pixel;
  logic                hit;

  // Clamp the geometry
  always_comb begin
    if (frame_width < WIDTH_W'(MIN_EXTENT)) begin
      eff_w = EFF_W'(MIN_EXTENT);
    end else if (EFF_W'(frame_width) > EFF_W'(MAX_WIDTH)) begin
      eff_w = EFF_W'(MAX_WIDTH);
    end else begin
      eff_w = EFF_W'(frame_width);
    end
    if (frame_height < HEIGHT_W'(MIN_EXTENT)) begin
      eff_h = HEIGHT_W'(MIN_EXTENT);
    end else begin
      eff_h = frame_height;
    end
  end

  assign w_m1 = COL_W'(eff_w - EFF_W'(1));
  assign h_m1 = eff_h - HEIGHT_W'(1);

  assign product = green_gain * green;
  assign fg      = !({{GAIN_W{1'b0}}, red} > product);

  assign accept      = pixel_valid && advance;
  assign pixel_stall = !advance;

  always_comb begin
    if (operation) begin
      emit = pending_count != '0;
    end else begin
      emit = pending_count >= eff_w + EFF_W'(1);
    end
  end

  assign sel_upper  = pending_count > eff_w;
  assign border     = out_row == '0 || out_row >= h_m1 ||
                      out_column == '0 || out_column >= w_m1;
  assign last_pixel = out_row == h_m1 && out_column == w_m1;

  // Drains read the oldest pending pixel, pixels their own column
  assign rd_addr = operation ? out_column : in_column;
  assign rd_en   = accept;

  // Write-back landing in the same cycle as this read
  assign hit = wr.en && wr.addr == rd_addr;

  assign restart = cfg_write && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      green_gain   <= GAIN_RESET;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN:   green_gain   <= cfg_data[GAIN_W-1:0];
        REG_WIDTH:  frame_width  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: frame_height <= cfg_data[HEIGHT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_column     <= '0;
      in_row        <= '0;
      out_column    <= '0;
      out_row       <= '0;
      pending_count <= '0;
    end else if (accept) begin
      if (!operation) begin
        if (in_column == w_m1) begin
          in_column <= '0;
          in_row    <= (in_row == h_m1) ? '0 : in_row + HEIGHT_W'(1);
        end else begin
          in_column <= in_column + COL_W'(1);
        end
      end
      if (emit) begin
        if (out_column == w_m1) begin
          out_column <= '0;
          out_row    <= (out_row == h_m1) ? '0 : out_row + HEIGHT_W'(1);
        end else begin
          out_column <= out_column + COL_W'(1);
        end
      end
      if (!operation && !emit) begin
        pending_count <= pending_count + EFF_W'(1);
      end else if (operation && emit) begin
        pending_count <= pending_count - EFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (advance) begin
      stage.valid <= accept;
    end
    if (accept) begin
      stage.pixel     <= !operation;
      stage.emit      <= emit;
      stage.border    <= border;
      stage.frame_end <= last_pixel;
      stage.sel_upper <= sel_upper;
      stage.fg        <= fg;
      stage.fwd       <= hit;
      stage.fwd_data  <= wr.data;
      stage.addr      <= rd_addr;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cmm_window.sv =====
// Back end: line memory write-back, 3x3 window register, grow, shrink
// and majority, and the result register. Depends on cmm_pkg.
`default_nettype none

module cmm_window (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       restart,
  input  wire cmm_pkg::cmm_stage_t        stage,
  input  wire logic [cmm_pkg::LINE_W-1:0] rd_data,
  output logic                            advance,
  output cmm_pkg::cmm_wr_t                wr,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic                            mask_bit,
  output logic                            grown_bit,
  output logic                            shrunk_bit,
  output logic                            majority_bit,
  output logic                            frame_end
);

  import cmm_pkg::*;

  logic [WIN_BITS-1:0]  window_bits;
  logic [WIN_BITS-1:0]  win_next;
  logic [LINE_W-1:0]    line;
  logic                 top;
  logic                 mid;
  logic [WIN_CNT_W-1:0] ones;
  logic                 load_out;
  logic                 m;
  logic                 g;
  logic                 s;
  logic                 maj;

  // Take the forwarded word where the write-back raced the read
  assign line = stage.fwd ? stage.fwd_data : rd_data;
  assign top  = line[LINE_UPPER];
  assign mid  = line[LINE_MIDDLE];

  // Newest column enters at the top of the window
  assign win_next = {stage.fg, mid, top, window_bits[WIN_BITS-1:3]};

  always_comb begin
    ones = '0;
    for (int i = 0; i < WIN_BITS; i++) begin
      ones = ones + WIN_CNT_W'(win_next[i]);
    end
  end

  assign load_out = !result_valid || !result_stall;
  assign advance  = !stage.valid || !stage.emit || load_out;

  always_comb begin
    wr.en                   = stage.valid && stage.pixel && advance;
    wr.addr                 = stage.addr;
    wr.data                 = '0;
    wr.data[LINE_UPPER]     = mid;
    wr.data[LINE_MIDDLE]    = stage.fg;
  end

  always_comb begin
    if (stage.pixel) begin
      m = win_next[CENTRE];
    end else begin
      m = stage.sel_upper ? top : mid;
    end
    if (stage.pixel && !stage.border) begin
      g   = |win_next;
      s   = &win_next;
      maj = ones > WIN_CNT_W'(MAJ_LIMIT);
    end else begin
      g   = m;
      s   = m;
      maj = m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      window_bits <= '0;
    end else if (wr.en) begin
      window_bits <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= stage.valid && stage.emit;
    end
    if (load_out && stage.valid && stage.emit) begin
      mask_bit     <= m;
      grown_bit    <= g;
      shrunk_bit   <= s;
      majority_bit <= maj;
      frame_end    <= stage.frame_end;
    end
  end

endmodule

`default_nettype wire

// ===== sv/color_mask_morphology_3x3_unit.sv =====
// Colour mask 3x3 morphology unit: one item per clock, sustained unless a stalled result blocks it.
// A pixel's result leaves with the item width+1 pixels later; drains flush one each.
// An accepted item passes through the stage register into the result register.
// Rate set by the read-modify-write of one line memory word per item, with forwarding.
// Reset: counters and window clear, registers take reset values; line memory kept.
`default_nettype none

module color_mask_morphology_3x3_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pixel_valid,
  output logic                               pixel_stall,
  input  wire logic                          operation,
  input  wire logic [cmm_pkg::GAIN_W-1:0]    red,
  input  wire logic [cmm_pkg::GAIN_W-1:0]    green,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic                               mask_bit,
  output logic                               grown_bit,
  output logic                               shrunk_bit,
  output logic                               majority_bit,
  output logic                               frame_end,
  input  wire logic                          cfg_write,
  input  wire logic [cmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cmm_pkg::CFG_W-1:0]     cfg_data
);

  import cmm_pkg::*;

  cmm_stage_t        stage;
  cmm_wr_t           wr;
  logic              advance;
  logic              restart;
  logic              rd_en;
  logic [COL_W-1:0]  rd_addr;
  logic [LINE_W-1:0] rd_data;

  cmm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .operation   (operation),
    .red         (red),
    .green       (green),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .advance     (advance),
    .wr          (wr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .stage       (stage),
    .restart     (restart)
  );

  // Upper and middle line share one word per column
  cmm_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cmm_window u_window (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .stage        (stage),
    .rd_data      (rd_data),
    .advance      (advance),
    .wr           (wr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .mask_bit     (mask_bit),
    .grown_bit    (grown_bit),
    .shrunk_bit   (shrunk_bit),
    .majority_bit (majority_bit),
    .frame_end    (frame_end)
  );

endmodule

`default_nettype wire

// ===== sv/cmm_checker.sv =====
// Port-level checks for the colour mask morphology unit, bound to the top level.
// No package dependencies; sees only the handshake and result ports.
`default_nettype none

module cmm_checker (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic pixel_valid,
  input  wire logic pixel_stall,
  input  wire logic result_valid,
  input  wire logic result_stall,
  input  wire logic mask_bit,
  input  wire logic grown_bit,
  input  wire logic shrunk_bit,
  input  wire logic majority_bit,
  input  wire logic frame_end
);

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable({mask_bit, grown_bit, shrunk_bit, majority_bit, frame_end}))
    else $error("stalled result changed");

  // Stall the input only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> result_valid && result_stall)
    else $error("input stalled without a blocked result");

  // A fresh result follows an accepted request
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pixel_valid && !pixel_stall, 2))
    else $error("result without a preceding request");

  // Shrink within mask and majority, both within grow
  a_result_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!shrunk_bit || (mask_bit && majority_bit)) &&
                     (!mask_bit || grown_bit) && (!majority_bit || grown_bit))
    else $error("morphology results inconsistent");

endmodule

bind color_mask_morphology_3x3_unit cmm_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/mask_morph_checker.sv =====
// Predictor and result check for the colour mask 3x3 morphology unit.
// Watches the request, result and register write ports; depends on cmm_pkg.
`timescale 1ns / 100ps

module mask_morph_checker
  import cmm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  input  logic                 pixel_stall,
  input  logic                 operation,
  input  logic [GAIN_W-1:0]    red,
  input  logic [GAIN_W-1:0]    green,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  logic                 mask_bit,
  input  logic                 grown_bit,
  input  logic                 shrunk_bit,
  input  logic                 majority_bit,
  input  logic                 frame_end,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   results_waiting
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic mask;
    logic grown;
    logic shrunk;
    logic majority;
    logic frame_last;
  } pixel_result_t;

  logic                upper_row  [MAX_WIDTH];
  logic                middle_row [MAX_WIDTH];
  logic [WIN_BITS-1:0] window;
  logic [EFF_W-1:0]    in_col;
  logic [EFF_W-1:0]    out_col;
  logic [EFF_W-1:0]    in_flight;
  logic [HEIGHT_W-1:0] in_line;
  logic [HEIGHT_W-1:0] out_line;
  logic [GAIN_W-1:0]   gain;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  pixel_result_t       expected_pixels [$];

  // Stale entries only ever feed window positions that no checked result uses
  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i]  = 1'b0;
      middle_row[i] = 1'b0;
    end
  end

  function automatic logic [EFF_W-1:0] active_width();
    if (width_reg < WIDTH_W'(MIN_EXTENT)) return EFF_W'(MIN_EXTENT);
    if (width_reg > WIDTH_W'(MAX_WIDTH)) return EFF_W'(MAX_WIDTH);
    return EFF_W'(width_reg);
  endfunction

  function automatic logic [HEIGHT_W-1:0] active_height();
    if (height_reg < HEIGHT_W'(MIN_EXTENT)) return HEIGHT_W'(MIN_EXTENT);
    return height_reg;
  endfunction

  task automatic restart_frame();
    window    = '0;
    in_col    = '0;
    out_col   = '0;
    in_line   = '0;
    out_line  = '0;
    in_flight = '0;
  endtask

  // Produce the oldest pixel in flight; centred says the window sits on it
  task automatic emit_oldest(input logic centred, output pixel_result_t res);
    logic [EFF_W-1:0]    w;
    logic [HEIGHT_W-1:0] h;
    logic [EFF_W-1:0]    col;
    logic                m;
    logic                border;
    w = active_width();
    h = active_height();
    col = (out_col < w) ? out_col : w - 1'b1;
    // a full row behind the newest pixel it has moved to the upper line
    m = (in_flight > w) ? upper_row[col] : middle_row[col];
    border = (out_line == '0) || (out_line >= h - 1'b1) ||
             (out_col == '0) || (out_col >= w - 1'b1);
    res.mask     = m;
    res.grown    = m;
    res.shrunk   = m;
    res.majority = m;
    if (!border && centred) begin
      res.mask     = window[CENTRE];
      res.grown    = |window;
      res.shrunk   = &window;
      res.majority = $countones(window) > MAJ_LIMIT;
    end
    res.frame_last = (out_line == h - 1'b1) && (out_col == w - 1'b1);
    out_col++;
    if (out_col >= w) begin
      out_col = '0;
      out_line++;
      if (out_line >= h) out_line = '0;
    end
    in_flight--;
  endtask

  task automatic take_request();
    logic [EFF_W-1:0]    w;
    logic [EFF_W-1:0]    c;
    logic [HEIGHT_W-1:0] h;
    logic [2*GAIN_W-1:0] product;
    logic                fg;
    logic                top_bit;
    logic                mid_bit;
    pixel_result_t       res;
    w = active_width();
    h = active_height();
    if (operation) begin
      if (in_flight != '0) begin
        emit_oldest(1'b0, res);
        expected_pixels.push_back(res);
      end
    end else begin
      product = gain * green;
      fg = !({{GAIN_W{1'b0}}, red} > product);
      c = (in_col < w) ? in_col : w - 1'b1;
      top_bit = upper_row[c];
      mid_bit = middle_row[c];
      upper_row[c]  = mid_bit;
      middle_row[c] = fg;
      // shift in the new column: top at the low bit, newest row at the high bit
      window = {fg, mid_bit, top_bit, window[WIN_BITS-1:3]};
      in_col++;
      if (in_col >= w) begin
        in_col = '0;
        in_line++;
        if (in_line >= h) in_line = '0;
      end
      in_flight++;
      if (in_flight >= w + 2'd2) begin
        emit_oldest(1'b1, res);
        expected_pixels.push_back(res);
      end
    end
  endtask

  task automatic check_result();
    pixel_result_t got;
    pixel_result_t want;
    got = {mask_bit, grown_bit, shrunk_bit, majority_bit, frame_end};
    if (expected_pixels.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: result with none expected: mask %0b grow %0b shrink %0b major %0b end %0b",
                 $time, got.mask, got.grown, got.shrunk, got.majority, got.frame_last);
    end else begin
      want = expected_pixels.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: mismatch mask %0b/%0b grow %0b/%0b shrink %0b/%0b major %0b/%0b end %0b/%0b (exp/got)",
                   $time, want.mask, got.mask, want.grown, got.grown, want.shrunk, got.shrunk,
                   want.majority, got.majority, want.frame_last, got.frame_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_frame();
      gain       = GAIN_RESET;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      expected_pixels.delete();
      mismatch_count = 0;
    end else begin
      if (result_valid && !result_stall) check_result();
      if (cfg_write) begin
        case (cfg_index)
          REG_GAIN: gain = cfg_data[GAIN_W-1:0];
          REG_WIDTH: begin
            width_reg = cfg_data[WIDTH_W-1:0];
            restart_frame();
          end
          REG_HEIGHT: begin
            height_reg = cfg_data[HEIGHT_W-1:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall) take_request();
    end
    results_waiting = expected_pixels.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the colour mask morphology testbench: clock, reset, stimulus and verdict.
// Instantiates color_mask_morphology_3x3_unit beside mask_morph_checker; uses cmm_pkg.
`timescale 1ns / 100ps

module tb;
  import cmm_pkg::*;

  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 8;
  localparam int HOLD_PHASE    = 4;
  localparam int FLUSH_LIMIT   = 20;
  localparam int DRAIN_CAP     = 8;
  localparam int MAX_GAP       = 40;

  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 pixel_valid  = 1'b0;
  logic                 operation    = 1'b0;
  logic [GAIN_W-1:0]    red          = '0;
  logic [GAIN_W-1:0]    green        = '0;
  logic                 result_stall = 1'b0;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 pixel_stall;
  logic                 result_valid;
  logic                 mask_bit;
  logic                 grown_bit;
  logic                 shrunk_bit;
  logic                 majority_bit;
  logic                 frame_end;
  int                   mismatch_count;
  int                   results_waiting;

  // Foreground ring round a background centre, colours at the threshold edges for gain 2
  logic [7:0] ring_red   [9] = '{8'd0, 8'd255, 8'd254, 8'd0, 8'd255, 8'd1, 8'd128, 8'd0, 8'd170};
  logic [7:0] ring_green [9] = '{8'd0, 8'd255, 8'd127, 8'd255, 8'd127, 8'd1, 8'd64, 8'd128, 8'd85};

  int ph_gain   [PHASES] = '{2, 0, 255, 1, 3, 77, 128, 5};
  int ph_width  [PHASES] = '{1, 5, 7, 4, 16, 2047, 3, 10};
  int ph_height [PHASES] = '{0, 4, 5, 4095, 6, 3, 3, 3};
  int ph_items  [PHASES] = '{100, 110, 110, 100, 120, 1040, 100, 100};

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_seq      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet         = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  color_mask_morphology_3x3_unit dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .operation    (operation),
    .red          (red),
    .green        (green),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .mask_bit     (mask_bit),
    .grown_bit    (grown_bit),
    .shrunk_bit   (shrunk_bit),
    .majority_bit (majority_bit),
    .frame_end    (frame_end),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  mask_morph_checker morph_check (
    .clk             (clk),
    .rst             (rst),
    .pixel_valid     (pixel_valid),
    .pixel_stall     (pixel_stall),
    .operation       (operation),
    .red             (red),
    .green           (green),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .mask_bit        (mask_bit),
    .grown_bit       (grown_bit),
    .shrunk_bit      (shrunk_bit),
    .majority_bit    (majority_bit),
    .frame_end       (frame_end),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_waiting (results_waiting)
  );

  // Result side: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Offer one request and hold it until taken; returns on the following falling edge
  task automatic push_request(input logic op, input logic [7:0] r, input logic [7:0] g);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    operation   <= op;
    red         <= r;
    green       <= g;
    do @(posedge clk); while (pixel_stall);
    @(negedge clk);
  endtask

  // Pick colours that land on the wanted side of the threshold, now and then raw noise
  task automatic push_pixel(input logic [7:0] gain_now, input int fg_pct);
    logic [7:0] r;
    logic [7:0] g;
    int         cap;
    if ($urandom_range(9) == 0) begin
      r = 8'($urandom);
      g = 8'($urandom);
    end else if ($urandom_range(99) < fg_pct) begin
      g = 8'($urandom);
      cap = gain_now * g;
      if (cap > 255) cap = 255;
      r = 8'($urandom_range(cap));
    end else begin
      cap = (gain_now == 0) ? 255 : 254 / gain_now;
      g = 8'($urandom_range(cap));
      r = 8'($urandom_range(255, gain_now * g + 1));
    end
    push_request(OP_PIXEL, r, g);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for every expected result, then let the pipeline empty of silent work
  task automatic settle();
    pixel_valid <= 1'b0;
    while (results_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = 72;
        stall_pct    <= 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct    <= 72;
      end
      IDLE_BOTH: begin
        send_idle_pct = 13;
        stall_pct    <= 13;
      end
      default: begin
        send_idle_pct = 0;
        stall_pct    <= 0;
      end
    endcase
  endtask

  initial begin
    int w;
    int drains;
    int fg_pct;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // drain with nothing in flight, at the reset geometry
    push_request(OP_DRAIN, 8'd0, 8'd0);
    settle();
    set_reg(REG_WIDTH, MIN_EXTENT);
    set_reg(REG_HEIGHT, MIN_EXTENT);
    // all-background frame straight into the ring frame, then flush and one idle drain
    repeat (9) push_request(OP_PIXEL, 8'd255, 8'd0);
    for (int i = 0; i < 9; i++) push_request(OP_PIXEL, ring_red[i], ring_green[i]);
    repeat (MIN_EXTENT + 2) push_request(OP_DRAIN, 8'hFF, 8'hFF);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_idling(p % 4);
      if (p == PHASES - 1) set_reg(REG_UNUSED, $urandom);
      set_reg(REG_GAIN, ph_gain[p]);
      set_reg(REG_WIDTH, ph_width[p]);
      set_reg(REG_HEIGHT, ph_height[p]);
      if (p == HOLD_PHASE) hold_seq <= hold_seq + 1;
      fg_pct = 50;
      for (int i = 0; i < ph_items[p]; i++) begin
        // clump the mask so that erosion and majority see full windows
        if (i % 8 == 0)
          fg_pct = ($urandom_range(2) == 0) ? 15 : (($urandom_range(1) == 0) ? 50 : 85);
        if ($urandom_range(99) < 4)
          push_request(OP_DRAIN, 8'($urandom), 8'($urandom));
        else
          push_pixel(8'(ph_gain[p]), fg_pct);
      end
      w = (ph_width[p] < MIN_EXTENT) ? MIN_EXTENT :
          ((ph_width[p] > MAX_WIDTH) ? MAX_WIDTH : ph_width[p]);
      // flush the tail; at the widest setting the next geometry write drops the rest
      drains = (w + 2 > FLUSH_LIMIT) ? DRAIN_CAP : w + 2;
      repeat (drains) push_request(OP_DRAIN, 8'($urandom), 8'($urandom));
    end

    set_idling(IDLE_NONE);
    settle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_waiting == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
